@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LDS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LDS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lds_pkg.sv @@
// ----------------------------------------------------------------------------
// lds_pkg
// Widths, item types, sequencer states and arithmetic unit types of the
// linear Diophantine solver.
// ----------------------------------------------------------------------------
package lds_pkg;

	localparam int DATA_WIDTH = 32;

	localparam logic [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [DATA_WIDTH-1:0] ONE     = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] coef_a;
		logic signed [DATA_WIDTH-1:0] coef_b;
		logic signed [DATA_WIDTH-1:0] rhs_c;
	} lds_coef_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] sol_x;
		logic signed [DATA_WIDTH-1:0] sol_y;
		logic                         solvable;
	} lds_sol_t;

	typedef enum logic {
		ALU_DIV,
		ALU_MUL
	} lds_alu_op_t;

	typedef struct packed {
		logic        start;
		lds_alu_op_t op;
	} lds_alu_req_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} lds_alu_st_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_GCD_TEST,
		ST_GCD_WAIT,
		ST_CDIV_WAIT,
		ST_EXT_TEST,
		ST_EXT_DIV_WAIT,
		ST_EXT_MUL,
		ST_EXT_MUL_WAIT,
		ST_TMUL,
		ST_TMUL_WAIT,
		ST_TDIV,
		ST_TDIV_WAIT,
		ST_XMUL,
		ST_XMUL_WAIT,
		ST_YMUL,
		ST_YMUL_WAIT,
		ST_RESULT
	} lds_state_t;

endpackage

@@ hdl/lds_alu.sv @@
// ----------------------------------------------------------------------------
// lds_alu
// Shared bit-serial arithmetic unit: signed truncating divide with remainder,
// or wrapping multiply, one bit per cycle through a single adder.
// ----------------------------------------------------------------------------
module lds_alu import lds_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lds_alu_req_t          req,
	input  logic [DATA_WIDTH-1:0] opa,
	input  logic [DATA_WIDTH-1:0] opb,
	output lds_alu_st_t           st,
	output logic [DATA_WIDTH-1:0] quo,
	output logic [DATA_WIDTH-1:0] rem,
	output logic [DATA_WIDTH-1:0] prod
);

	localparam int CntW = $clog2(DATA_WIDTH);
	localparam logic [CntW-1:0] LastStep = CntW'(DATA_WIDTH - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CntW-1:0]       cnt_q;
	lds_alu_op_t           op_q;
	logic [DATA_WIDTH-1:0] x_q;
	logic [DATA_WIDTH-1:0] y_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic                  qneg_q;
	logic                  rneg_q;

	logic [DATA_WIDTH-1:0] abs_a;
	logic [DATA_WIDTH-1:0] abs_b;
	logic [DATA_WIDTH:0]   add_a;
	logic [DATA_WIDTH:0]   add_b;
	logic                  sub;
	logic [DATA_WIDTH:0]   sum;

	assign abs_a = opa[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - opa) : opa;
	assign abs_b = opb[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - opb) : opb;

	// The one adder: trial subtract for division, accumulate for multiply.
	always_comb begin
		unique case (op_q)
			ALU_DIV: begin
				add_a = {acc_q, x_q[DATA_WIDTH-1]};
				add_b = {1'b0, y_q};
				sub   = 1'b1;
			end
			ALU_MUL: begin
				add_a = {1'b0, acc_q};
				add_b = y_q[0] ? {1'b0, x_q} : '0;
				sub   = 1'b0;
			end
		endcase
		sum = add_a + (sub ? ~add_b : add_b) + {{DATA_WIDTH{1'b0}}, sub};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= ALU_DIV;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				op_q   <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			if (req.op == ALU_DIV) begin
				x_q    <= abs_a;
				y_q    <= abs_b;
				qneg_q <= opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
				rneg_q <= opa[DATA_WIDTH-1];
			end else begin
				x_q    <= opa;
				y_q    <= opb;
				qneg_q <= 1'b0;
				rneg_q <= 1'b0;
			end
		end else if (busy_q) begin
			unique case (op_q)
				ALU_DIV: begin
					if (!sum[DATA_WIDTH]) begin
						acc_q <= sum[DATA_WIDTH-1:0];
						x_q   <= {x_q[DATA_WIDTH-2:0], 1'b1};
					end else begin
						acc_q <= {acc_q[DATA_WIDTH-2:0], x_q[DATA_WIDTH-1]};
						x_q   <= {x_q[DATA_WIDTH-2:0], 1'b0};
					end
				end
				ALU_MUL: begin
					acc_q <= sum[DATA_WIDTH-1:0];
					x_q   <= {x_q[DATA_WIDTH-2:0], 1'b0};
					y_q   <= {1'b0, y_q[DATA_WIDTH-1:1]};
				end
			endcase
		end
	end

	assign quo         = qneg_q ? (DATA_WIDTH'(0) - x_q) : x_q;
	assign rem         = rneg_q ? (DATA_WIDTH'(0) - acc_q) : acc_q;
	assign prod        = acc_q;
	assign st.done     = done_q;
	assign st.rem_zero = (acc_q == '0);

endmodule

@@ hdl/linear_diophantine_solver.sv @@
// ----------------------------------------------------------------------------
// linear_diophantine_solver
// Each input item carries signed coefficients a, b and right-hand side c; the
// block returns one result item with integers x, y such that a*x + b*y = c,
// or a cleared solvable flag with both x and y at the minimum integer when c
// is not a multiple of gcd(a, b) or when a and b are both zero. The gcd comes
// from plain Euclid with the larger input taken first, so its sign follows
// truncating remainders and may be negative; x and y come from the extended
// Euclid loop on the original a and b, scaled by c/gcd, all two's complement
// and wrapping at DATA_WIDTH bits. One item is worked at a time, and the
// block stalls its input until the result has been moved into the output
// register. All divisions and multiplications go through one bit-serial
// unit, so latency grows with the number of Euclid rounds, gcd rounds and
// extended rounds (at most about 46 of each), on top of the remainder test,
// the cofactor and the scaling. With b zero the cofactor steps are skipped
// and the extended loop does not run; an item with both coefficients zero
// goes straight to the result.
// ----------------------------------------------------------------------------
module linear_diophantine_solver import lds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      coef_valid,
	output logic      coef_stall,
	input  lds_coef_t coef,
	output logic      sol_valid,
	input  logic      sol_stall,
	output lds_sol_t  sol
);

	lds_state_t state_q;
	lds_state_t state_d;

	// Operands of the current item.
	logic [DATA_WIDTH-1:0] a_q;
	logic [DATA_WIDTH-1:0] b_q;
	logic [DATA_WIDTH-1:0] c_q;
	logic                  fail_q;

	// Plain Euclid pair, then c/gcd.
	logic [DATA_WIDTH-1:0] p_q;
	logic [DATA_WIDTH-1:0] q_q;
	logic [DATA_WIDTH-1:0] cq_q;

	// Extended Euclid state and the final cofactors.
	logic [DATA_WIDTH-1:0] old_r_q;
	logic [DATA_WIDTH-1:0] r_q;
	logic [DATA_WIDTH-1:0] old_s_q;
	logic [DATA_WIDTH-1:0] s_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] t_q;
	logic [DATA_WIDTH-1:0] x_q;
	logic [DATA_WIDTH-1:0] y_q;

	// Output register.
	logic     sol_valid_q;
	lds_sol_t sol_q;
	logic     sol_load;

	// Shared arithmetic unit.
	lds_alu_req_t          alu_req;
	lds_alu_st_t           alu_st;
	logic [DATA_WIDTH-1:0] alu_a;
	logic [DATA_WIDTH-1:0] alu_b;
	logic [DATA_WIDTH-1:0] alu_quo;
	logic [DATA_WIDTH-1:0] alu_rem;
	logic [DATA_WIDTH-1:0] alu_prod;

	lds_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (alu_a),
		.opb    (alu_b),
		.st     (alu_st),
		.quo    (alu_quo),
		.rem    (alu_rem),
		.prod   (alu_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: each arithmetic step issues one start to the shared unit in
	// its own state and then waits in the matching wait state for done.
	always_comb begin
		state_d       = state_q;
		coef_stall    = 1'b1;
		alu_req.start = 1'b0;
		alu_req.op    = ALU_DIV;
		alu_a         = '0;
		alu_b         = '0;
		sol_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				coef_stall = 1'b0;
				if (coef_valid) begin
					// Both coefficients zero has no gcd and is reported unsolvable.
					if (coef.coef_a == '0 && coef.coef_b == '0) begin
						state_d = ST_RESULT;
					end else begin
						state_d = ST_GCD_TEST;
					end
				end
			end
			ST_GCD_TEST: begin
				alu_req.start = 1'b1;
				alu_req.op    = ALU_DIV;
				if (q_q == '0) begin
					// p now holds the gcd; divide c by it for the test and scale.
					alu_a   = c_q;
					alu_b   = p_q;
					state_d = ST_CDIV_WAIT;
				end else begin
					alu_a   = p_q;
					alu_b   = q_q;
					state_d = ST_GCD_WAIT;
				end
			end
			ST_GCD_WAIT: begin
				if (alu_st.done) begin
					state_d = ST_GCD_TEST;
				end
			end
			ST_CDIV_WAIT: begin
				if (alu_st.done) begin
					state_d = alu_st.rem_zero ? ST_EXT_TEST : ST_RESULT;
				end
			end
			ST_EXT_TEST: begin
				if (r_q == '0) begin
					state_d = (b_q == '0) ? ST_XMUL : ST_TMUL;
				end else begin
					alu_req.start = 1'b1;
					alu_req.op    = ALU_DIV;
					alu_a         = old_r_q;
					alu_b         = r_q;
					state_d       = ST_EXT_DIV_WAIT;
				end
			end
			ST_EXT_DIV_WAIT: begin
				if (alu_st.done) begin
					state_d = ST_EXT_MUL;
				end
			end
			ST_EXT_MUL: begin
				alu_req.start = 1'b1;
				alu_req.op    = ALU_MUL;
				alu_a         = quo_q;
				alu_b         = s_q;
				state_d       = ST_EXT_MUL_WAIT;
			end
			ST_EXT_MUL_WAIT: begin
				if (alu_st.done) begin
					state_d = ST_EXT_TEST;
				end
			end
			ST_TMUL: begin
				alu_req.start = 1'b1;
				alu_req.op    = ALU_MUL;
				alu_a         = old_s_q;
				alu_b         = a_q;
				state_d       = ST_TMUL_WAIT;
			end
			ST_TMUL_WAIT: begin
				if (alu_st.done) begin
					state_d = ST_TDIV;
				end
			end
			ST_TDIV: begin
				alu_req.start = 1'b1;
				alu_req.op    = ALU_DIV;
				alu_a         = t_q;
				alu_b         = b_q;
				state_d       = ST_TDIV_WAIT;
			end
			ST_TDIV_WAIT: begin
				if (alu_st.done) begin
					state_d = ST_XMUL;
				end
			end
			ST_XMUL: begin
				alu_req.start = 1'b1;
				alu_req.op    = ALU_MUL;
				alu_a         = old_s_q;
				alu_b         = cq_q;
				state_d       = ST_XMUL_WAIT;
			end
			ST_XMUL_WAIT: begin
				if (alu_st.done) begin
					state_d = ST_YMUL;
				end
			end
			ST_YMUL: begin
				alu_req.start = 1'b1;
				alu_req.op    = ALU_MUL;
				alu_a         = t_q;
				alu_b         = cq_q;
				state_d       = ST_YMUL_WAIT;
			end
			ST_YMUL_WAIT: begin
				if (alu_st.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				// Move the result out as soon as the output register is free.
				if (!sol_valid_q || !sol_stall) begin
					sol_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath registers follow the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (coef_valid) begin
					a_q    <= coef.coef_a;
					b_q    <= coef.coef_b;
					c_q    <= coef.rhs_c;
					fail_q <= (coef.coef_a == '0 && coef.coef_b == '0);
					// Larger value first for the gcd pass.
					if ($signed(coef.coef_b) > $signed(coef.coef_a)) begin
						p_q <= coef.coef_b;
						q_q <= coef.coef_a;
					end else begin
						p_q <= coef.coef_a;
						q_q <= coef.coef_b;
					end
				end
			end
			ST_GCD_WAIT: begin
				if (alu_st.done) begin
					p_q <= q_q;
					q_q <= alu_rem;
				end
			end
			ST_CDIV_WAIT: begin
				if (alu_st.done) begin
					cq_q    <= alu_quo;
					fail_q  <= !alu_st.rem_zero;
					old_r_q <= a_q;
					r_q     <= b_q;
					old_s_q <= ONE;
					s_q     <= '0;
				end
			end
			ST_EXT_TEST: begin
				if (r_q == '0 && b_q == '0) begin
					t_q <= '0;
				end
			end
			ST_EXT_DIV_WAIT: begin
				// The truncating remainder equals old_r - quo*r modulo 2^W.
				if (alu_st.done) begin
					quo_q   <= alu_quo;
					old_r_q <= r_q;
					r_q     <= alu_rem;
				end
			end
			ST_EXT_MUL_WAIT: begin
				if (alu_st.done) begin
					old_s_q <= s_q;
					s_q     <= old_s_q - alu_prod;
				end
			end
			ST_TMUL_WAIT: begin
				if (alu_st.done) begin
					t_q <= old_r_q - alu_prod;
				end
			end
			ST_TDIV_WAIT: begin
				if (alu_st.done) begin
					t_q <= alu_quo;
				end
			end
			ST_XMUL_WAIT: begin
				if (alu_st.done) begin
					x_q <= alu_prod;
				end
			end
			ST_YMUL_WAIT: begin
				if (alu_st.done) begin
					y_q <= alu_prod;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sol_valid_q <= 1'b0;
		end else begin
			if (sol_load) begin
				sol_valid_q <= 1'b1;
			end else if (!sol_stall) begin
				sol_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sol_load) begin
			sol_q.sol_x    <= fail_q ? INT_MIN : x_q;
			sol_q.sol_y    <= fail_q ? INT_MIN : y_q;
			sol_q.solvable <= !fail_q;
		end
	end

	assign sol_valid = sol_valid_q;
	assign sol       = sol_q;

endmodule

@@ hdl/lds_checker.sv @@
// ----------------------------------------------------------------------------
// lds_checker
// Port-level assertions for the linear Diophantine solver, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lds_checker import lds_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     coef_valid,
	input logic     coef_stall,
	input logic     sol_valid,
	input logic     sol_stall,
	input lds_sol_t sol
);

	// An unsolvable result carries the minimum integer in both fields.
	`LDS_ASSERT_IMP(a_unsolvable_min, sol_valid && !sol.solvable, sol.sol_x == INT_MIN && sol.sol_y == INT_MIN, "unsolvable result without minimum integer")

	// Once an item is taken, the input stalls while it is being worked.
	`LDS_ASSERT_NXT(a_busy_after_accept, coef_valid && !coef_stall, coef_stall, "input not stalled after accepting an item")

	// A result that waits keeps its value.
	`LDS_ASSERT_NXT(a_sol_hold, sol_valid && sol_stall, sol_valid && $stable(sol), "stalled result changed")

	// A new result only appears at the end of work on an item.
	`LDS_ASSERT_IMP(a_sol_from_work, $rose(sol_valid), $past(coef_stall), "result appeared while the block was idle")

endmodule

bind linear_diophantine_solver lds_checker u_lds_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.coef_valid (coef_valid),
	.coef_stall (coef_stall),
	.sol_valid  (sol_valid),
	.sol_stall  (sol_stall),
	.sol        (sol)
);

@@ bench/linear_diophantine_solver_test.sv @@
// ----------------------------------------------------------------------------
// linear_diophantine_solver_test
// Self-checking bench for the linear Diophantine solver. Every accepted item
// is solved by an in-bench integer model at the block's width, and the
// result is queued. Each result the block hands over is compared field by
// field against the oldest queued solution. Stimulus is a directed corner set
// followed by random problems; both channels idle at random except in the final stretch.
// ----------------------------------------------------------------------------
module linear_diophantine_solver_test;
	import lds_pkg::*;

	// The largest positive word. It is paired with INT_MIN from the package
	// to probe the overflow corners.
	localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = ~INT_MIN;

	// The slowest correct item takes about 46 gcd rounds and 46 extended
	// rounds. That is paid about 430 times, plus the idling on each side.
	// The cycle limit is several times that total.
	localparam int CYCLE_LIMIT  = 10_000_000;
	localparam int DRAIN_CYCLES = 500;

	// A solution waiting to come out of the block. The problem is kept beside
	// the answer so that a mismatch can name the item that caused it.
	typedef struct packed {
		lds_coef_t problem;
		lds_sol_t  answer;
	} pending_solution_t;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      coef_valid = 1'b0;
	logic      coef_stall;
	lds_coef_t coef       = '0;
	logic      sol_valid;
	logic      sol_stall  = 1'b0;
	lds_sol_t  sol;

	pending_solution_t pending_solutions[$];
	pending_solution_t oldest;
	int                error_count = 0;
	int                cycle_count = 0;
	int                stall_left  = 0;
	bit                idling_on   = 1'b1;

	linear_diophantine_solver dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef_valid (coef_valid),
		.coef_stall (coef_stall),
		.coef       (coef),
		.sol_valid  (sol_valid),
		.sol_stall  (sol_stall),
		.sol        (sol)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Integer model. All values are held in longint and brought back to
	// the word width after every operation, so wrapping matches the block.
	// SystemVerilog division and remainder truncate toward zero, the same
	// way the hardware does.
	// ------------------------------------------------------------------

	// Sign-extends the low word of v. This is how every wrapped result is
	// formed.
	function automatic longint wrap_word(input longint v);
		logic signed [DATA_WIDTH-1:0] w;
		w = v[DATA_WIDTH-1:0];
		return longint'(w);
	endfunction

	// Dividing the minimum integer by -1 overflows. The quotient then wraps
	// back to the minimum integer.
	function automatic longint trunc_quotient(input longint n, input longint d);
		if (d == -1)
			return wrap_word(-n);
		return wrap_word(n / d);
	endfunction

	function automatic longint trunc_remainder(input longint n, input longint d);
		if (d == -1)
			return 0;
		return n % d;
	endfunction

	// Plain Euclid with the larger value taken first. The sign of the gcd
	// falls out of the truncating remainders, so it can be negative. The
	// caller makes sure the two inputs are not both zero.
	function automatic longint euclid_gcd(input longint a, input longint b);
		longint p, q, tmp;
		p = a;
		q = b;
		if (q > p) begin
			tmp = p;
			p   = q;
			q   = tmp;
		end
		while (q != 0) begin
			tmp = q;
			q   = trunc_remainder(p, q);
			p   = tmp;
		end
		return p;
	endfunction

	function automatic lds_sol_t solve_diophantine(input lds_coef_t item);
		longint   a, b, c, g, s, old_s, r, old_r, quo, tmp, t, scale;
		lds_sol_t res;
		a            = longint'(item.coef_a);
		b            = longint'(item.coef_b);
		c            = longint'(item.rhs_c);
		res.sol_x    = INT_MIN;
		res.sol_y    = INT_MIN;
		res.solvable = 1'b0;
		// With both coefficients zero, or with c not a multiple of the gcd,
		// there is no solution.
		if (a == 0 && b == 0)
			return res;
		g = euclid_gcd(a, b);
		if (trunc_remainder(c, g) != 0)
			return res;
		// The extended loop runs on the original a and b, not on the
		// swapped pair.
		s     = 0;
		old_s = 1;
		r     = b;
		old_r = a;
		while (r != 0) begin
			quo   = trunc_quotient(old_r, r);
			tmp   = old_r;
			old_r = r;
			r     = wrap_word(tmp - wrap_word(quo * r));
			tmp   = old_s;
			old_s = s;
			s     = wrap_word(tmp - wrap_word(quo * s));
		end
		if (b != 0)
			t = trunc_quotient(wrap_word(old_r - wrap_word(old_s * a)), b);
		else
			t = 0;
		scale        = trunc_quotient(c, g);
		res.sol_x    = DATA_WIDTH'(wrap_word(old_s * scale));
		res.sol_y    = DATA_WIDTH'(wrap_word(t * scale));
		res.solvable = 1'b1;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------

	// Random word with a mix of magnitudes. Small values give short Euclid
	// runs and often a gcd above one. Full-range words reach every bit.
	// Shifted words land in between, and the special words hit the overflow
	// corners.
	function automatic logic signed [DATA_WIDTH-1:0] rand_word();
		logic signed [DATA_WIDTH-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				v = int'($urandom_range(0, 40)) - 20;
			end
			4, 5, 6: begin
				v = $urandom();
			end
			7, 8: begin
				v = $urandom() >> $urandom_range(1, DATA_WIDTH - 1);
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			default: begin
				case ($urandom_range(0, 5))
					0:       v = INT_MIN;
					1:       v = WORD_MAX;
					2:       v = 0;
					3:       v = 1;
					4:       v = -1;
					default: v = INT_MIN + 1;
				endcase
			end
		endcase
		return v;
	endfunction

	// Offers one item and holds it until the block takes it. The expected
	// solution is queued at the edge where the item is accepted. Sometimes
	// the valid line then drops for a short burst.
	task automatic send_problem(input logic signed [DATA_WIDTH-1:0] a,
	                            input logic signed [DATA_WIDTH-1:0] b,
	                            input logic signed [DATA_WIDTH-1:0] c);
		lds_coef_t         item;
		pending_solution_t entry;
		item.coef_a = a;
		item.coef_b = b;
		item.rhs_c  = c;
		coef       <= item;
		coef_valid <= 1'b1;
		@(posedge clk);
		while (coef_stall)
			@(posedge clk);
		entry.problem = item;
		entry.answer  = solve_diophantine(item);
		pending_solutions.push_back(entry);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			coef_valid <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(posedge clk);
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// The directed set covers both coefficients zero, a zero on either side,
	// and c off the gcd lattice. It also covers the minimum integer divided
	// by -1, negative gcds, wrapping products, and a Fibonacci pair that
	// forces the longest Euclid run.
	task automatic test_corner_cases();
		send_problem(0, 0, 0);
		send_problem(0, 0, 5);
		send_problem(3, 5, 7);
		send_problem(6, 9, 4);
		send_problem(6, 9, -12);
		send_problem(0, 7, 21);
		send_problem(7, 0, -14);
		send_problem(INT_MIN, -1, 1);
		send_problem(-1, INT_MIN, INT_MIN);
		send_problem(INT_MIN, INT_MIN, INT_MIN);
		send_problem(WORD_MAX, WORD_MAX, INT_MIN);
		send_problem(WORD_MAX, INT_MIN, WORD_MAX);
		send_problem(INT_MIN, 0, INT_MIN);
		send_problem(0, INT_MIN, 0);
		send_problem(-1, -1, INT_MIN);
		send_problem(1, -1, WORD_MAX);
		send_problem(WORD_MAX, WORD_MAX - 1, 32'sh1234_5678);
		send_problem(1836311903, 1134903170, 1);
		send_problem(-1836311903, 1134903170, -7);
		send_problem(12, -18, INT_MIN);
		send_problem(-12, -18, 6);
		send_problem(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F);
	endtask

	// In this test c is a random multiple of the gcd, so most items reach
	// the extended loop and the scaling.
	task automatic test_solvable_problems(input int count);
		logic signed [DATA_WIDTH-1:0] a, b, c;
		longint                       g;
		repeat (count) begin
			a = rand_word();
			b = rand_word();
			if (a == 0 && b == 0)
				b = 1;
			g = euclid_gcd(longint'(a), longint'(b));
			if ($urandom_range(0, 3) == 0)
				c = DATA_WIDTH'(wrap_word(g * longint'($signed($urandom()))));
			else
				c = DATA_WIDTH'(wrap_word(g * (int'($urandom_range(0, 100)) - 50)));
			send_problem(a, b, c);
		end
	endtask

	// All three fields are free, so unsolvable items turn up here as well.
	task automatic test_arbitrary_problems(input int count);
		repeat (count)
			send_problem(rand_word(), rand_word(), rand_word());
	endtask

	// The closing stretch runs with no idling on either side, so that the
	// block is seen back to back.
	task automatic test_without_idling(input int count);
		idling_on = 1'b0;
		test_solvable_problems(count / 2);
		test_arbitrary_problems(count - count / 2);
	endtask

	// Drops valid and waits for the queue to empty. The extra cycles after
	// that are there to catch a stray result.
	task automatic drain_results();
		coef_valid <= 1'b0;
		while (pending_solutions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side.
	// ------------------------------------------------------------------

	// The receiver stalls in bursts of random length while idling is on.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			sol_stall <= 1'b1;
			stall_left--;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			sol_stall  <= 1'b1;
			stall_left = $urandom_range(0, 4);
		end else begin
			sol_stall <= 1'b0;
		end
	end

	// Every result accepted at this edge is checked against the oldest
	// pending solution.
	always @(posedge clk) begin
		if (arst_n && sol_valid && !sol_stall) begin
			if (pending_solutions.size() == 0) begin
				report_mismatch($sformatf("result x=%0d y=%0d ok=%0b with none expected",
					sol.sol_x, sol.sol_y, sol.solvable));
			end else begin
				oldest = pending_solutions.pop_front();
				if (sol.solvable !== oldest.answer.solvable)
					report_mismatch($sformatf("a=%0d b=%0d c=%0d: solvable %b, expected %b",
						oldest.problem.coef_a, oldest.problem.coef_b,
						oldest.problem.rhs_c, sol.solvable, oldest.answer.solvable));
				if (sol.sol_x !== oldest.answer.sol_x)
					report_mismatch($sformatf("a=%0d b=%0d c=%0d: x %0d, expected %0d",
						oldest.problem.coef_a, oldest.problem.coef_b,
						oldest.problem.rhs_c, sol.sol_x, oldest.answer.sol_x));
				if (sol.sol_y !== oldest.answer.sol_y)
					report_mismatch($sformatf("a=%0d b=%0d c=%0d: y %0d, expected %0d",
						oldest.problem.coef_a, oldest.problem.coef_b,
						oldest.problem.rhs_c, sol.sol_y, oldest.answer.sol_y));
			end
		end
	end

	// Watchdog. If the run does not finish within the cycle limit, a result
	// was lost or the block hung.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, pending_solutions.size());
		$display("** linear_diophantine_solver: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequence of tests.
	// ------------------------------------------------------------------
	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_solvable_problems(150);
		test_arbitrary_problems(150);
		test_without_idling(100);
		drain_results();
		if (error_count == 0)
			$display("** linear_diophantine_solver: PASSED **");
		else
			$display("** linear_diophantine_solver: FAILED **");
		$finish;
	end

endmodule
